[hw/rtl/mct_pkg.sv]
package mct_pkg;

  localparam int CHANNELS = 8;
  localparam int MASK_W   = 8;
  localparam int CNT_W    = 32;
  localparam int TPM_W    = 16;
  localparam int DELAY_W  = 16;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 32;

  localparam logic [CNT_W-1:0] MAX_COUNT_RST  = 32'hFFFF_FFFF;
  localparam logic [TPM_W-1:0] TICKS_PER_MS_RST = 16'd500;
  localparam logic [CNT_W-1:0] LARGEST_IVL_RST = 32'h0000_FFFF;

  typedef enum logic [1:0] {
    OP_TICK   = 2'd0,
    OP_START  = 2'd1,
    OP_CANCEL = 2'd2,
    OP_REPEAT = 2'd3
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MAX_COUNT    = 2'd0,
    CFG_TICKS_PER_MS = 2'd1,
    CFG_LARGEST_IVL  = 2'd2,
    CFG_UNUSED       = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    logic [1:0]         operation;
    logic [2:0]         channel;
    logic [DELAY_W-1:0] delay_ms;
    logic               repeat_enable;
  } in_item_t;

  typedef struct packed {
    logic [MASK_W-1:0] fired_mask;
    logic [MASK_W-1:0] done_mask;
    logic [CNT_W-1:0]  counter_value;
    logic              late;
  } out_item_t;

  // Input item held in the first stage, with its delay already scaled to ticks.
  typedef struct packed {
    in_item_t          item;
    logic [CNT_W-1:0]  prod;
  } staged_t;

  typedef struct packed {
    logic               go;
    logic               tick;
    logic               start;
    logic               cancel;
    logic               set_rep;
    logic               rep_val;
    logic [CNT_W-1:0]   start_prod;
    logic [DELAY_W-1:0] start_delay;
  } chan_cmd_t;

  typedef struct packed {
    logic fired;
    logic done;
    logic late;
  } chan_stat_t;

  function automatic logic [CNT_W-1:0] count_next(input logic [CNT_W-1:0] cnt,
                                                   input logic [CNT_W-1:0] max_cnt);
    count_next = (cnt >= max_cnt) ? '0 : cnt + 1'b1;
  endfunction

endpackage

[hw/rtl/mct_in_stage.sv]
module mct_in_stage (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  mct_pkg::in_item_t             in_data,
  input  logic [mct_pkg::TPM_W-1:0]     ticks_per_ms,
  input  logic                          advance,
  output logic                          q_valid,
  output mct_pkg::staged_t              q_item
);
  import mct_pkg::*;

  logic [CNT_W-1:0] prod;

  assign prod     = CNT_W'(in_data.delay_ms) * CNT_W'(ticks_per_ms);
  assign in_ready = !q_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      q_valid <= 1'b0;
    end else if (in_ready) begin
      q_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      q_item.item <= in_data;
      q_item.prod <= prod;
    end
  end

endmodule

[hw/rtl/mct_chan.sv]
module mct_chan (
  input  logic                          clk,
  input  logic                          rst,
  input  mct_pkg::chan_cmd_t            cmd,
  input  logic                          hit,
  input  logic [mct_pkg::CNT_W-1:0]     cnt,
  input  logic [mct_pkg::CNT_W-1:0]     cnt_nx,
  input  logic [mct_pkg::CNT_W-1:0]     count_limit,
  input  logic [mct_pkg::CNT_W-1:0]     late_limit,
  input  logic [mct_pkg::TPM_W-1:0]     ticks_per_ms,
  output mct_pkg::chan_stat_t           stat
);
  import mct_pkg::*;

  logic               en;
  logic               rep;
  logic               done;
  logic               force_fire;
  logic [CNT_W-1:0]   cmp;
  logic [DELAY_W-1:0] delay_len;
  logic [CNT_W-1:0]   prod;

  logic               match;
  logic               rearm;
  logic               arm_start;
  logic [CNT_W-1:0]   base;
  logic [CNT_W-1:0]   addend;
  logic [CNT_W-1:0]   val;
  logic [CNT_W-1:0]   span;
  logic               late_calc;
  logic               done_next;

  assign match     = cmd.tick && en && (force_fire || cmp == cnt_nx);
  assign rearm     = match && rep;
  assign arm_start = cmd.start && hit;

  // A tick rearms from the advanced counter, a start from the current one.
  assign base      = cmd.tick ? cnt_nx : cnt;
  assign addend    = cmd.tick ? prod : cmd.start_prod;
  assign val       = addend + base;
  assign span      = (val & count_limit) - base;
  assign late_calc = !(span < late_limit);

  always_comb begin
    done_next = done;
    if (match) begin
      done_next = 1'b1;
    end else if (arm_start) begin
      done_next = 1'b0;
    end
  end

  assign stat.fired = match;
  assign stat.done  = done_next;
  assign stat.late  = late_calc && (rearm || arm_start);

  always_ff @(posedge clk) begin
    if (rst) begin
      en         <= 1'b0;
      rep        <= 1'b0;
      done       <= 1'b0;
      force_fire <= 1'b0;
    end else if (cmd.go) begin
      done <= done_next;
      if (match) begin
        force_fire <= rearm && late_calc;
        en         <= rep;
      end else if (arm_start) begin
        en         <= 1'b1;
        force_fire <= late_calc;
      end else if (cmd.cancel && hit) begin
        en         <= 1'b0;
        force_fire <= 1'b0;
      end else if (cmd.set_rep && hit) begin
        rep <= cmd.rep_val;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.go && (rearm || arm_start)) begin
      cmp <= val;
    end
    if (cmd.go && arm_start) begin
      delay_len <= cmd.start_delay;
      prod      <= cmd.start_prod;
    end else begin
      // Track the tick scale so a repeat rearm sees the current setting.
      prod <= CNT_W'(delay_len) * CNT_W'(ticks_per_ms);
    end
  end

endmodule

[hw/rtl/multichannel_compare_timer.sv]
// Channel  Direction  Payload                                   Handshake
// in       input      in_data: operation/channel/delay/repeat   in_valid, in_ready
// out      output     out_data: fired/done masks, counter, late out_valid, out_ready
// cfg      input      cfg_index, cfg_data                       cfg_valid, cfg_ready
//
// One item per cycle unless the output stalls: an item is registered on entry, is
// processed once the output is free and lands in the output register with out_valid.
// The per-channel compare, rearm add and late check sit between those two registers.
// Synchronous active-high reset clears the counter, all channel flags and both valid bits.
// A stalled output holds its item; the input register takes one more item, then the
// input stalls until the output drains.
// Configuration writes are always taken, one per cycle.
module multichannel_compare_timer (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  mct_pkg::in_item_t                 in_data,
  output logic                              out_valid,
  input  logic                              out_ready,
  output mct_pkg::out_item_t                out_data,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [mct_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [mct_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import mct_pkg::*;

  logic [CNT_W-1:0] count_limit;
  logic [TPM_W-1:0] ticks_per_ms;
  logic [CNT_W-1:0] late_limit;

  logic [CNT_W-1:0] cnt;
  logic [CNT_W-1:0] cnt_nx;

  logic             q_valid;
  staged_t          q_item;
  logic             go;
  logic             is_tick;
  chan_cmd_t        cmd;
  chan_stat_t       stat [CHANNELS];
  logic [CHANNELS-1:0] hit;
  logic [CHANNELS-1:0] late_bits;
  out_item_t        result;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      count_limit  <= MAX_COUNT_RST;
      ticks_per_ms <= TICKS_PER_MS_RST;
      late_limit   <= LARGEST_IVL_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_MAX_COUNT:    count_limit  <= cfg_data;
        CFG_TICKS_PER_MS: ticks_per_ms <= cfg_data[TPM_W-1:0];
        CFG_LARGEST_IVL:  late_limit   <= cfg_data;
        default: ;
      endcase
    end
  end

  mct_in_stage u_in (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_data      (in_data),
    .ticks_per_ms (ticks_per_ms),
    .advance      (go),
    .q_valid      (q_valid),
    .q_item       (q_item)
  );

  assign go      = q_valid && (!out_valid || out_ready);
  assign is_tick = (q_item.item.operation == OP_TICK);

  assign cmd.go          = go;
  assign cmd.tick        = is_tick;
  assign cmd.start       = (q_item.item.operation == OP_START);
  assign cmd.cancel      = (q_item.item.operation == OP_CANCEL);
  assign cmd.set_rep     = (q_item.item.operation == OP_REPEAT);
  assign cmd.rep_val     = q_item.item.repeat_enable;
  assign cmd.start_prod  = q_item.prod;
  assign cmd.start_delay = q_item.item.delay_ms;

  // cnt_nx holds the next tick's counter value; it is registered and lags a limit write.
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt    <= '0;
      cnt_nx <= CNT_W'(1);
    end else if (go && is_tick) begin
      cnt    <= cnt_nx;
      cnt_nx <= count_next(cnt_nx, count_limit);
    end else begin
      cnt_nx <= count_next(cnt, count_limit);
    end
  end

  for (genvar i = 0; i < CHANNELS; i++) begin : g_chan
    assign hit[i]       = (32'(q_item.item.channel) == i);
    assign late_bits[i] = stat[i].late;

    mct_chan u_chan (
      .clk          (clk),
      .rst          (rst),
      .cmd          (cmd),
      .hit          (hit[i]),
      .cnt          (cnt),
      .cnt_nx       (cnt_nx),
      .count_limit  (count_limit),
      .late_limit   (late_limit),
      .ticks_per_ms (ticks_per_ms),
      .stat         (stat[i])
    );
  end

  for (genvar b = 0; b < MASK_W; b++) begin : g_mask
    if (b < CHANNELS) begin : g_live
      assign result.fired_mask[b] = stat[b].fired;
      assign result.done_mask[b]  = stat[b].done;
    end else begin : g_pad
      assign result.fired_mask[b] = 1'b0;
      assign result.done_mask[b]  = 1'b0;
    end
  end

  assign result.counter_value = is_tick ? cnt_nx : cnt;
  assign result.late          = |late_bits;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (go) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      out_data <= result;
    end
  end

`ifndef SYNTHESIS
  a_fired_is_done: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((out_data.fired_mask & ~out_data.done_mask) == '0))
    else $error("fired channel not marked done");

  a_no_fire_off_tick: assert property (@(posedge clk) disable iff (rst)
    (go && !is_tick) |=> (out_data.fired_mask == '0))
    else $error("channel fired on a non-tick item");

  a_tick_counter: assert property (@(posedge clk) disable iff (rst)
    (go && is_tick) |=> (cnt == $past(cnt_nx) && out_data.counter_value == cnt))
    else $error("tick did not advance counter to precomputed value");
`endif

endmodule

[tb/mct_checker.sv]
`timescale 1ns / 1ps

module mct_checker (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  input  logic                           in_ready,
  input  mct_pkg::in_item_t              in_data,
  input  logic                           out_valid,
  input  logic                           out_ready,
  input  mct_pkg::out_item_t             out_data,
  input  logic                           cfg_valid,
  input  logic                           cfg_ready,
  input  logic [mct_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [mct_pkg::CFG_DATA_W-1:0] cfg_data,
  output int                             errors,
  output int                             pending
);
  import mct_pkg::*;

  logic [CNT_W-1:0]    wrap_at;
  logic [TPM_W-1:0]    ticks_ms;
  logic [CNT_W-1:0]    late_gap;
  logic [CNT_W-1:0]    count;
  logic [CNT_W-1:0]    target [CHANNELS];
  logic [DELAY_W-1:0]  period [CHANNELS];
  logic [CHANNELS-1:0] armed;
  logic [CHANNELS-1:0] looping;
  logic [CHANNELS-1:0] finished;
  logic [CHANNELS-1:0] forced;
  out_item_t           awaited [$];
  out_item_t           want;
  int                  mismatches;

  assign errors = mismatches;

  // Set the compare point of one channel from the current count; returns the late flag.
  function automatic logic arm_compare(input int ch, input logic [DELAY_W-1:0] ms);
    logic [CNT_W-1:0] hit;
    logic [CNT_W-1:0] gap;
    hit = CNT_W'(ms) * CNT_W'(ticks_ms) + count;
    gap = (hit & wrap_at) - count;
    target[ch] = hit;
    armed[ch]  = 1'b1;
    period[ch] = ms;
    forced[ch] = (gap >= late_gap);
    return forced[ch];
  endfunction

  function automatic out_item_t advance_timer(input in_item_t it);
    out_item_t           res;
    logic [CHANNELS-1:0] fired;
    logic                slip;
    int                  ch;
    int                  i;
    fired = '0;
    slip  = 1'b0;
    ch    = int'(it.channel);
    if (it.operation == OP_TICK) begin
      count = (count >= wrap_at) ? '0 : count + 1'b1;
      for (i = 0; i < CHANNELS; i++) begin
        if (armed[i] && (forced[i] || target[i] == count)) begin
          fired[i]    = 1'b1;
          finished[i] = 1'b1;
          forced[i]   = 1'b0;
          if (looping[i]) begin
            if (arm_compare(i, period[i])) slip = 1'b1;
          end else begin
            armed[i] = 1'b0;
          end
        end
      end
    end else if (ch < CHANNELS) begin
      case (it.operation)
        OP_START: begin
          finished[ch] = 1'b0;
          slip = arm_compare(ch, it.delay_ms);
        end
        OP_CANCEL: begin
          armed[ch]  = 1'b0;
          forced[ch] = 1'b0;
        end
        default: looping[ch] = it.repeat_enable;
      endcase
    end
    res.fired_mask    = MASK_W'(fired);
    res.done_mask     = MASK_W'(finished);
    res.counter_value = count;
    res.late          = slip;
    return res;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      wrap_at    = MAX_COUNT_RST;
      ticks_ms   = TICKS_PER_MS_RST;
      late_gap   = LARGEST_IVL_RST;
      count      = '0;
      armed      = '0;
      looping    = '0;
      finished   = '0;
      forced     = '0;
      mismatches = 0;
      for (int i = 0; i < CHANNELS; i++) begin
        target[i] = '0;
        period[i] = '0;
      end
      awaited.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (awaited.size() == 0) begin
          $error("result with no item outstanding, counter_value %0h",
                 out_data.counter_value);
          mismatches++;
        end else begin
          want = awaited.pop_front();
          if (out_data.fired_mask !== want.fired_mask) begin
            $error("fired_mask: expected %0h, actual %0h", want.fired_mask,
                   out_data.fired_mask);
            mismatches++;
          end
          if (out_data.done_mask !== want.done_mask) begin
            $error("done_mask: expected %0h, actual %0h", want.done_mask,
                   out_data.done_mask);
            mismatches++;
          end
          if (out_data.counter_value !== want.counter_value) begin
            $error("counter_value: expected %0h, actual %0h", want.counter_value,
                   out_data.counter_value);
            mismatches++;
          end
          if (out_data.late !== want.late) begin
            $error("late: expected %0b, actual %0b", want.late, out_data.late);
            mismatches++;
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_MAX_COUNT:    wrap_at  = cfg_data;
          CFG_TICKS_PER_MS: ticks_ms = cfg_data[TPM_W-1:0];
          CFG_LARGEST_IVL:  late_gap = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && in_ready) awaited.push_back(advance_timer(in_data));
    end
    pending <= awaited.size();
  end

endmodule

[tb/testbench.sv]
`timescale 1ns / 1ps

module testbench;
  import mct_pkg::*;

  localparam int PHASE_ITEMS = 190;
  localparam int HOLD_CYCLES = 250;

  logic                  clk;
  logic                  rst;
  logic                  in_valid;
  logic                  in_ready;
  in_item_t              in_data;
  logic                  out_valid;
  logic                  out_ready;
  out_item_t             out_data;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  int                    errors;
  int                    pending;
  logic                  calm;

  multichannel_compare_timer DUT (.*);

  mct_checker watch (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  function automatic in_item_t make_item(input op_t op, input logic [2:0] ch,
                                         input logic [DELAY_W-1:0] ms, input logic rep);
    in_item_t it;
    it.operation     = op;
    it.channel       = ch;
    it.delay_ms      = ms;
    it.repeat_enable = rep;
    return it;
  endfunction

  function automatic in_item_t random_command();
    in_item_t it;
    int       pick;
    pick = $urandom_range(99);
    if (pick < 55) it.operation = OP_TICK;
    else if (pick < 80) it.operation = OP_START;
    else if (pick < 88) it.operation = OP_CANCEL;
    else it.operation = OP_REPEAT;
    it.channel = 3'($urandom_range(7));
    pick = $urandom_range(9);
    // mostly short delays so compares are reached within a phase
    if (pick < 7) it.delay_ms = DELAY_W'($urandom_range(12));
    else if (pick == 7) it.delay_ms = $urandom_range(1) ? 16'hFFFF : 16'h0000;
    else it.delay_ms = DELAY_W'($urandom);
    it.repeat_enable = 1'($urandom_range(1));
    return it;
  endfunction

  task automatic push_item(input in_item_t it);
    if (!calm) begin
      while ($urandom_range(99) < 25) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (!in_ready);
  endtask

  // Drop valid and wait until every item has produced its result.
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic run_setting(input logic [CNT_W-1:0] top_count,
                             input logic [CNT_W-1:0] tpm,
                             input logic [CNT_W-1:0] late_at);
    cfg_idx_t        regs [3];
    logic [CNT_W-1:0] vals [3];
    regs = '{CFG_MAX_COUNT, CFG_TICKS_PER_MS, CFG_LARGEST_IVL};
    vals = '{top_count, tpm & 32'h0000_FFFF, late_at};
    settle();
    for (int k = 0; k < 3; k++) begin
      cfg_valid <= 1'b1;
      cfg_index <= regs[k];
      cfg_data  <= vals[k];
      do @(posedge clk); while (!cfg_ready);
    end
    cfg_valid <= 1'b0;
    repeat (PHASE_ITEMS) push_item(random_command());
  endtask

  // Receiver: random back-pressure plus two long hold-offs so the block fills up.
  initial begin
    int taken;
    int hold;
    taken = 0;
    hold  = 0;
    out_ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (out_valid && out_ready) begin
        taken++;
        if (taken == 300 || taken == 1000) hold = HOLD_CYCLES;
      end
      if (hold > 0) begin
        hold--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= calm || ($urandom_range(99) >= 25);
      end
      @(posedge clk);
    end
  end

  initial begin
    logic [CNT_W-1:0] top_count;
    rst       <= 1'b1;
    calm      <= 1'b0;
    in_valid  <= 1'b0;
    in_data   <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= CFG_MAX_COUNT;
    cfg_data  <= '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // reset settings: zero delay, late starts, repeat rearm, cancel of a forced channel
    push_item(make_item(OP_TICK,   3'd0, 16'h0000, 1'b0));
    push_item(make_item(OP_START,  3'd0, 16'h0000, 1'b0));
    push_item(make_item(OP_START,  3'd1, 16'hFFFF, 1'b0));
    push_item(make_item(OP_START,  3'd7, 16'h0001, 1'b1));
    push_item(make_item(OP_REPEAT, 3'd1, 16'h0000, 1'b1));
    push_item(make_item(OP_TICK,   3'd5, 16'h5555, 1'b0));
    push_item(make_item(OP_TICK,   3'd2, 16'hAAAA, 1'b1));
    push_item(make_item(OP_REPEAT, 3'd1, 16'h0000, 1'b0));
    push_item(make_item(OP_TICK,   3'd0, 16'h0000, 1'b0));
    push_item(make_item(OP_CANCEL, 3'd7, 16'h0000, 1'b0));
    push_item(make_item(OP_START,  3'd2, 16'd131,  1'b0));
    push_item(make_item(OP_START,  3'd3, 16'd132,  1'b0));
    push_item(make_item(OP_CANCEL, 3'd3, 16'hFFFF, 1'b1));
    push_item(make_item(OP_TICK,   3'd7, 16'hFFFF, 1'b1));
    push_item(make_item(OP_REPEAT, 3'd5, 16'h0000, 1'b1));
    push_item(make_item(OP_START,  3'd5, 16'hAAAA, 1'b0));
    push_item(make_item(OP_TICK,   3'd0, 16'h0000, 1'b0));
    push_item(make_item(OP_CANCEL, 3'd5, 16'h0000, 1'b0));
    push_item(make_item(OP_REPEAT, 3'd5, 16'h0000, 1'b0));
    push_item(make_item(OP_START,  3'd4, 16'h5555, 1'b1));
    push_item(make_item(OP_START,  3'd6, 16'h0001, 1'b0));
    push_item(make_item(OP_TICK,   3'd0, 16'h0000, 1'b0));

    run_setting(32'hFFFF_FFFF, 32'd1, 32'hFFFF_FFFF);
    // counter is above the new maximum here, so the next tick wraps
    run_setting(32'd40, 32'd2, 32'd25);
    run_setting(32'd1, 32'd65535, 32'd1);
    run_setting(32'd0, 32'd0, 32'd0);
    calm <= 1'b1;
    top_count = $urandom_range(60, 5);
    run_setting(top_count, $urandom_range(4, 1), $urandom_range(top_count + 2, 1));
    calm <= 1'b0;
    run_setting(MAX_COUNT_RST, 32'(TICKS_PER_MS_RST), LARGEST_IVL_RST);
    run_setting($urandom_range(32'hFFFF_FFFF, 1), $urandom_range(65535, 1),
                $urandom_range(32'hFFFF_FFFF, 1));
    top_count = $urandom_range(30, 3);
    run_setting(top_count, $urandom_range(3, 1), $urandom_range(top_count + 2, 1));

    settle();
    repeat (8) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
